/* rtl/bswt_pkg.sv */
// Package for the block stream window tracker: sizes, payload structs, codes.
// No dependencies.
package bswt_pkg;
  localparam int MAX_STREAMS = 16;
  localparam int WINDOW_BITS = 256;
  localparam int ADDR_W = 48;
  localparam int IDX_W = $clog2(MAX_STREAMS);
  localparam int DIST_W = $clog2(WINDOW_BITS);
  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};
  localparam logic [7:0] FIELD_LIMIT = 8'd255;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_FETCHED = 1'b1;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_FETCH = 2'd2;

  typedef struct packed {
    logic operation;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic ready_res;
    logic [7:0] request_offset;
    logic [7:0] request_count;
    logic [1:0] error;
  } out_item_t;
endpackage

/* rtl/bswt_queue.sv */
// Two-entry item queue between the front and back parts.
// Depends on bswt_pkg.
module bswt_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  bswt_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output bswt_pkg::in_item_t out_data
);
  import bswt_pkg::*;
  in_item_t slot [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;

  assign in_ready = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data = slot[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_data;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/bswt_front.sv */
// Front part: takes input items, masks the operation code and queues them.
// Depends on bswt_pkg and bswt_queue.
module bswt_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  bswt_pkg::in_item_t in_data,
  output logic q_valid,
  input  logic q_ready,
  output bswt_pkg::in_item_t q_data
);
  import bswt_pkg::*;
  in_item_t cls;
  always_comb begin
    cls = in_data;
    cls.operation = (in_data.operation == OP_FETCHED) ? OP_FETCHED : OP_CHECK;
  end
  bswt_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(cls),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );
endmodule

/* rtl/bswt_back.sv */
// Back part: table search, entry update, front advance and tail extension.
// Depends on bswt_pkg.
module bswt_back (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] window_blocks,
  input  logic q_valid,
  output logic q_ready,
  input  bswt_pkg::in_item_t q_data,
  output logic out_valid,
  input  logic out_ready,
  output bswt_pkg::out_item_t out_data
);
  import bswt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_ADV = 3'd3;
  localparam logic [2:0] S_CAP = 3'd4;
  localparam logic [2:0] S_EXT = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [2:0] state;
  in_item_t item;
  logic [MAX_STREAMS-1:0] valid;
  logic [ADDR_W-1:0] st_start [MAX_STREAMS];
  logic [ADDR_W-1:0] st_head [MAX_STREAMS];
  logic [ADDR_W-1:0] st_tail [MAX_STREAMS];
  logic [ADDR_W-1:0] st_front [MAX_STREAMS];
  logic [WINDOW_BITS-1:0] st_map [MAX_STREAMS];

  logic [IDX_W:0] scan_i;
  logic [IDX_W-1:0] scan_idx;
  logic best_ok;
  logic [IDX_W-1:0] best;
  logic free_ok;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] sel;
  logic [ADDR_W-1:0] limit;
  logic [ADDR_W-1:0] old_tail;
  out_item_t res;

  logic [ADDR_W-1:0] cur_start, cur_head, cur_tail, cur_front, gap;
  logic hit, gap_ok;
  logic [ADDR_W:0] hw_sum;
  logic [ADDR_W:0] cnt_wide;

  assign scan_idx = scan_i[IDX_W-1:0];
  assign cur_start = st_start[best];
  assign cur_tail = st_tail[best];
  assign cur_front = st_front[best];
  assign cur_head = st_head[sel];
  assign hit = best_ok && (cur_tail > item.block_address);
  assign gap = item.block_address - cur_front;
  assign gap_ok = gap < ADDR_W'(WINDOW_BITS);
  assign hw_sum = {1'b0, cur_head} + {{ADDR_W-7{1'b0}}, window_blocks};
  assign cnt_wide = {1'b0, limit} - {1'b0, old_tail};

  assign q_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;
  assign out_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            item <= q_data;
            scan_i <= '0;
            best_ok <= 1'b0;
            free_ok <= 1'b0;
            res <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one entry a cycle: owner search and first free slot
          if (valid[scan_idx]) begin
            if (st_start[scan_idx] <= item.block_address &&
                (!best_ok || st_start[scan_idx] > st_start[best])) begin
              best <= scan_idx;
              best_ok <= 1'b1;
            end
          end else if (!free_ok) begin
            free_idx <= scan_idx;
            free_ok <= 1'b1;
          end
          if (scan_i == (IDX_W+1)'(MAX_STREAMS-1)) state <= S_DECIDE;
          scan_i <= scan_i + 1'b1;
        end
        S_DECIDE: begin
          if (item.operation == OP_CHECK) begin
            if (hit || (best_ok && cur_start == item.block_address)) begin
              sel <= best;
              old_tail <= cur_tail;
              if (item.block_address < cur_front) begin
                res.ready_res <= 1'b1;
                if (item.block_address > st_head[best])
                  st_head[best] <= st_head[best] + 1'b1;
              end
              state <= S_CAP;
            end else if (free_ok) begin
              sel <= free_idx;
              valid[free_idx] <= 1'b1;
              st_start[free_idx] <= item.block_address;
              st_head[free_idx] <= item.block_address;
              st_tail[free_idx] <= item.block_address;
              st_front[free_idx] <= item.block_address;
              st_map[free_idx] <= '0;
              old_tail <= item.block_address;
              state <= S_CAP;
            end else begin
              res.error <= ERR_FULL;
              state <= S_OUT;
            end
          end else begin
            if (!hit || item.block_address < cur_front || !gap_ok ||
                st_map[best][gap[DIST_W-1:0]]) begin
              res.error <= ERR_FETCH;
              state <= S_OUT;
            end else begin
              sel <= best;
              old_tail <= cur_tail;
              st_map[best][gap[DIST_W-1:0]] <= 1'b1;
              state <= S_ADV;
            end
          end
        end
        S_ADV: begin
          // move the front one block a cycle past fetched blocks
          if (st_map[sel][0]) begin
            st_map[sel] <= st_map[sel] >> 1;
            st_front[sel] <= st_front[sel] + 1'b1;
          end else begin
            state <= S_CAP;
          end
        end
        S_CAP: begin
          limit <= hw_sum[ADDR_W] ? ADDR_MAX : hw_sum[ADDR_W-1:0];
          scan_i <= '0;
          state <= S_EXT;
        end
        S_EXT: begin
          if (valid[scan_idx] && st_start[scan_idx] > st_start[sel] &&
              st_start[scan_idx] < limit)
            limit <= st_start[scan_idx];
          scan_i <= scan_i + 1'b1;
          if (scan_i == (IDX_W+1)'(MAX_STREAMS)) begin
            if (old_tail >= item.block_address)
              res.request_offset <= (old_tail - item.block_address > ADDR_W'(FIELD_LIMIT))
                ? FIELD_LIMIT : 8'(old_tail - item.block_address);
            if (limit > old_tail) begin
              res.request_count <= (cnt_wide > (ADDR_W+1)'(FIELD_LIMIT))
                ? FIELD_LIMIT : cnt_wide[7:0];
              st_tail[sel] <= limit;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/block_stream_window_tracker.sv */
// Channel | dir | payload
// in      | in  | operation, block_address
// out     | out | ready_res, request_offset, request_count, error
// cfg     | in  | window_blocks (8 bits)
// With the back part idle, a check runs an owner scan and a next-start scan over
// the table, a valid fetch also advances the front past fetched blocks, and a
// rejected item runs only the owner scan.
// Reset clears all streams and sets window_blocks to 32; a stalled result
// holds the back part while the queue still takes up to two items.
// Depends on bswt_pkg, bswt_front, bswt_back.
module block_stream_window_tracker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  bswt_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output bswt_pkg::out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_data
);
  import bswt_pkg::*;
  logic [7:0] window_blocks;
  logic q_valid, q_ready;
  in_item_t q_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) window_blocks <= 8'd32;
    else if (cfg_valid) window_blocks <= cfg_data;
  end

  bswt_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );
  bswt_back u_back (
    .clk(clk), .rst(rst), .window_blocks(window_blocks),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule

/* rtl/bswt_checker.sv */
// Port-level checks for the tracker, bound to the top level.
// Depends on bswt_pkg.
module bswt_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input bswt_pkg::out_item_t out_data
);
  import bswt_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error != ERR_NONE |->
      !out_data.ready_res && out_data.request_count == 8'd0 &&
      out_data.request_offset == 8'd0)
    else $error("error result carries data");
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.error != 2'd3)
    else $error("bad error code");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind block_stream_window_tracker bswt_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);

/* sim/block_stream_window_tracker_tb.sv */
// Testbench for block_stream_window_tracker: directed table, then random streams,
// each result checked against a typed row or stream table. Depends on bswt_pkg.
`timescale 1ns / 100ps
module block_stream_window_tracker_tb;
  import bswt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  block_stream_window_tracker dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioral copy of the stream table
  logic [7:0] win;
  logic tab_valid [MAX_STREAMS];
  logic [ADDR_W-1:0] tab_start [MAX_STREAMS];
  logic [ADDR_W-1:0] tab_head [MAX_STREAMS];
  logic [ADDR_W-1:0] tab_tail [MAX_STREAMS];
  logic [ADDR_W-1:0] tab_front [MAX_STREAMS];
  logic [WINDOW_BITS-1:0] tab_map [MAX_STREAMS];

  out_item_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int full_seen = 0;
  int fetch_err_seen = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_off = 0;

  function automatic logic [7:0] clip8(logic [ADDR_W:0] v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic void table_reset();
    win = 8'd32;
    for (int i = 0; i < MAX_STREAMS; i++) begin
      tab_valid[i] = 1'b0;
      tab_start[i] = '0;
      tab_head[i] = '0;
      tab_tail[i] = '0;
      tab_front[i] = '0;
      tab_map[i] = '0;
    end
  endfunction

  function automatic void grow_tail(int s, logic [ADDR_W-1:0] a, ref out_item_t r);
    logic [ADDR_W:0] lim;
    logic [ADDR_W-1:0] old;
    lim = {1'b0, tab_head[s]} + {{ADDR_W-7{1'b0}}, win};
    old = tab_tail[s];
    if (lim > {1'b0, ADDR_MAX}) lim = {1'b0, ADDR_MAX};
    for (int i = 0; i < MAX_STREAMS; i++)
      if (tab_valid[i] && tab_start[i] > tab_start[s] && tab_start[i] < lim)
        lim = {1'b0, tab_start[i]};
    r.request_offset = (old >= a) ? clip8({1'b0, old - a}) : 8'd0;
    if (lim > {1'b0, old}) begin
      r.request_count = clip8(lim - {1'b0, old});
      tab_tail[s] = lim[ADDR_W-1:0];
    end else begin
      r.request_count = 8'd0;
    end
  endfunction

  function automatic out_item_t track_access(in_item_t it);
    out_item_t r;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] d;
    int s;
    logic hit;
    r = '0;
    a = it.block_address;
    s = -1;
    for (int i = 0; i < MAX_STREAMS; i++)
      if (tab_valid[i] && tab_start[i] <= a && (s < 0 || tab_start[i] > tab_start[s]))
        s = i;
    hit = (s >= 0) && (tab_tail[s] > a);
    if (it.operation == OP_CHECK) begin
      if (!hit && !(s >= 0 && tab_start[s] == a)) begin
        s = -1;
        for (int i = 0; i < MAX_STREAMS; i++)
          if (!tab_valid[i] && s < 0) s = i;
        if (s >= 0) begin
          tab_valid[s] = 1'b1;
          tab_start[s] = a;
          tab_head[s] = a;
          tab_tail[s] = a;
          tab_front[s] = a;
          tab_map[s] = '0;
        end
      end
      if (s < 0) begin
        r.error = ERR_FULL;
      end else begin
        if (a < tab_front[s]) begin
          r.ready_res = 1'b1;
          if (a > tab_head[s]) tab_head[s] = tab_head[s] + 1;
        end
        grow_tail(s, a, r);
      end
    end else begin
      d = hit ? a - tab_front[s] : '0;
      if (!hit || a < tab_front[s] || d >= WINDOW_BITS || tab_map[s][d[DIST_W-1:0]]) begin
        r.error = ERR_FETCH;
      end else begin
        tab_map[s][d[DIST_W-1:0]] = 1'b1;
        while (tab_map[s][0]) begin
          tab_map[s] = tab_map[s] >> 1;
          tab_front[s] = tab_front[s] + 1;
        end
        grow_tail(s, a, r);
      end
    end
    return r;
  endfunction

  // output side: random stall, long hold-off on request, compare
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result act=%p", $time, out_data);
        errors <= errors + 1;
      end else begin
        if (out_data !== expected_q[0]) begin
          $display("%0t: mismatch exp=%p act=%p", $time, expected_q[0], out_data);
          errors <= errors + 1;
        end
        if (expected_q[0].error == ERR_FULL) full_seen <= full_seen + 1;
        if (expected_q[0].error == ERR_FETCH) fetch_err_seen <= fetch_err_seen + 1;
        void'(expected_q.pop_front());
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // directed rows; exp_known marks rows whose result is typed in
  typedef struct {
    in_item_t it;
    logic exp_known;
    out_item_t exp;
  } row_t;

  // offer one item and return at the edge that takes it; valid stays up
  task automatic send_item(in_item_t it, logic exp_known, out_item_t exp);
    out_item_t p;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    p = track_access(it);
    if (exp_known && p !== exp)
      $display("%0t: table row disagrees with predictor exp=%p pred=%p", $time, exp, p);
    in_valid <= 1'b1;
    in_data <= it;
    expected_q.push_back(exp_known ? exp : p);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_window(logic [7:0] w);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win = w;
  endtask

  function automatic in_item_t mk(logic op, logic [ADDR_W-1:0] a);
    in_item_t it;
    it.operation = op;
    it.block_address = a;
    return it;
  endfunction

  function automatic out_item_t res(logic rd, logic [7:0] o, logic [7:0] c, logic [1:0] e);
    out_item_t r;
    r.ready_res = rd;
    r.request_offset = o;
    r.request_count = c;
    r.error = e;
    return r;
  endfunction

  // random accesses, mostly close to the open stream starts, with fetches more often than checks
  task automatic random_phase(int n);
    logic [ADDR_W-1:0] bases [4];
    logic [ADDR_W-1:0] a;
    int k;
    bases[0] = 48'd1000;
    bases[1] = 48'd0;
    bases[2] = 48'h5555_5555_0000;
    bases[3] = ADDR_MAX - 48'd5;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(3);
      case ($urandom_range(9))
        0: a = ADDR_W'({$urandom, $urandom});
        1: a = bases[k] + 48'd300 + $urandom_range(3);
        default: a = bases[k] + $urandom_range(40);
      endcase
      send_item(mk($urandom_range(9) < 6 ? OP_FETCHED : OP_CHECK, a), 1'b0, '0);
    end
  endtask

  initial begin
    row_t rows[$];
    table_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{mk(OP_FETCHED, 48'd0), 1'b1, res(0, 0, 0, ERR_FETCH)});
    rows.push_back('{mk(OP_CHECK, 48'd1000), 1'b1, res(0, 0, 32, ERR_NONE)});
    rows.push_back('{mk(OP_CHECK, 48'd1000), 1'b1, res(0, 32, 0, ERR_NONE)});
    rows.push_back('{mk(OP_FETCHED, 48'd1001), 1'b0, '0});
    rows.push_back('{mk(OP_FETCHED, 48'd1001), 1'b1, res(0, 0, 0, ERR_FETCH)});
    rows.push_back('{mk(OP_FETCHED, 48'd1000), 1'b0, '0});
    rows.push_back('{mk(OP_CHECK, 48'd1001), 1'b0, '0});
    rows.push_back('{mk(OP_CHECK, 48'd1020), 1'b0, '0});
    rows.push_back('{mk(OP_FETCHED, 48'd1033), 1'b1, res(0, 0, 0, ERR_FETCH)});
    rows.push_back('{mk(OP_FETCHED, 48'd999), 1'b1, res(0, 0, 0, ERR_FETCH)});
    rows.push_back('{mk(OP_CHECK, 48'd1010), 1'b0, '0});
    rows.push_back('{mk(OP_CHECK, 48'd1040), 1'b0, '0});
    rows.push_back('{mk(OP_CHECK, ADDR_MAX), 1'b1, res(0, 0, 0, ERR_NONE)});
    rows.push_back('{mk(OP_CHECK, ADDR_MAX - 48'd5), 1'b0, '0});
    rows.push_back('{mk(OP_CHECK, 48'd0), 1'b1, res(0, 0, 32, ERR_NONE)});
    rows.push_back('{mk(OP_FETCHED, 48'hAAAA_AAAA_AAAA), 1'b0, '0});
    for (int i = 0; i < 11; i++)
      rows.push_back('{mk(OP_CHECK, 48'h5555_5555_0000 + 48'd512 * i), 1'b0, '0});
    rows.push_back('{mk(OP_CHECK, 48'h7000_0000_0000), 1'b1, res(0, 0, 0, ERR_FULL)});

    send_idle = 9;
    recv_idle = 64;
    foreach (rows[i])
      send_item(rows[i].it, rows[i].exp_known, rows[i].exp);
    drain();

    // the table is full now: keep working the open streams under other windows
    write_window(8'd1);
    random_phase(60);
    drain();
    write_window(8'd255);
    send_idle = 64;
    recv_idle = 9;
    hold_off = 300;
    random_phase(150);
    drain();
    write_window(8'd17);
    send_idle = 0;
    recv_idle = 0;
    random_phase(210);
    drain();

    $display("Covered %0d results: %0d table-full and %0d bad-fetch errors, windows 32/1/255/17.",
             results_seen, full_seen, fetch_err_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
